// ----- rtl/core/ffc_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the four-connected flood fill core.
// No dependencies; imported by ffc_nbr_unit and four_connected_flood_fill_core.
package ffc_pkg;

    localparam int POS_W        = 10;
    localparam int LABEL_PORT_W = 32;
    localparam int COUNT_W      = 21;
    localparam int CFG_DATA_W   = 11;
    localparam int CFG_INDEX_W  = 2;
    localparam int DIM_CMP_W    = 14;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_FILL  = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        DIR_RIGHT = 2'd0,
        DIR_LEFT  = 2'd1,
        DIR_DOWN  = 2'd2,
        DIR_UP    = 2'd3
    } dir_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RDATA,
        S_TEST,
        S_POP,
        S_LOAD,
        S_NBR
    } state_t;

    function automatic dir_t next_dir(input dir_t d);
        dir_t r;
        case (d)
            DIR_RIGHT: r = DIR_LEFT;
            DIR_LEFT:  r = DIR_DOWN;
            DIR_DOWN:  r = DIR_UP;
            default:   r = DIR_UP;
        endcase
        return r;
    endfunction

endpackage

// ----- rtl/core/ffc_ram.sv -----
`timescale 1ns / 1ps
// Simple dual-port RAM with one write port and one registered read port.
// Used for the label image and for the coordinate stack; no dependencies.
module ffc_ram #(
    parameter int DATA_W = 32,
    parameter int DEPTH  = 1024
) (
    input  logic                                        clk,
    input  logic                                        wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [DATA_W-1:0]                           wr_data,
    input  logic                                        rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [DATA_W-1:0]                           rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- rtl/core/ffc_nbr_unit.sv -----
`timescale 1ns / 1ps
// Shared neighbor step unit: bounds test and coordinate step for one direction.
// Depends on ffc_pkg.
module ffc_nbr_unit
    import ffc_pkg::*;
#(
    parameter int XW = 10,
    parameter int YW = 10,
    parameter int WW = 11,
    parameter int HW = 11
) (
    input  logic [XW-1:0] cur_x,
    input  logic [YW-1:0] cur_y,
    input  dir_t          dir,
    input  logic [WW-1:0] width,
    input  logic [HW-1:0] height,
    output logic          nbr_ok,
    output logic [XW-1:0] nbr_x,
    output logic [YW-1:0] nbr_y
);

    logic [DIM_CMP_W-1:0] x_ext;
    logic [DIM_CMP_W-1:0] y_ext;
    logic [DIM_CMP_W-1:0] x_inc;
    logic [DIM_CMP_W-1:0] y_inc;

    assign x_ext = DIM_CMP_W'(cur_x);
    assign y_ext = DIM_CMP_W'(cur_y);
    assign x_inc = x_ext + DIM_CMP_W'(1);
    assign y_inc = y_ext + DIM_CMP_W'(1);

    always_comb
    begin
        nbr_ok = 1'b0;
        nbr_x  = cur_x;
        nbr_y  = cur_y;
        case (dir)
            DIR_RIGHT:
            begin
                nbr_ok = x_inc < DIM_CMP_W'(width);
                nbr_x  = XW'(x_inc);
            end
            DIR_LEFT:
            begin
                nbr_ok = x_ext != '0;
                nbr_x  = XW'(x_ext - DIM_CMP_W'(1));
            end
            DIR_DOWN:
            begin
                nbr_ok = y_inc < DIM_CMP_W'(height);
                nbr_y  = YW'(y_inc);
            end
            default:
            begin
                nbr_ok = y_ext != '0;
                nbr_y  = YW'(y_ext - DIM_CMP_W'(1));
            end
        endcase
    end

endmodule

// ----- rtl/core/four_connected_flood_fill_core.sv -----
`timescale 1ns / 1ps
// Four-connected flood fill core: label image, coordinate stack and sequencer.
// Depends on ffc_pkg, ffc_ram and ffc_nbr_unit.
//
// Usage:
//   Input items transfer when in_valid is high and in_stall is low; results
//   transfer when out_valid is high and out_stall is low. Every item gives
//   exactly one result. Configuration writes (cfg_write_en, cfg_index,
//   cfg_data) set the image width and height; the user must make them only
//   while idle, as the core itself does not enforce this. Write and unknown
//   items have their result registered at the edge that accepts them. A read
//   passes through S_RDATA, as the label RAM read port is registered. A fill
//   tests the seed in S_TEST, pops each relabelled pixel (S_POP, S_LOAD) and
//   bounds-checks each of its four neighbors in S_NBR, reading one inside
//   there for the compare and write in S_TEST; a final S_POP with an empty
//   stack ends it, all paced by the single label RAM read port. The core
//   takes no new item while a fill or read is under way. A stalled result
//   holds in the output register; the core accepts one more item only if
//   that register drains at the same edge. Reset clears the sequencer and the
//   output valid flag and sets width and height to 1024 clamped to the maximum;
//   RAM contents are undefined until written, so no clearing pass runs.
module four_connected_flood_fill_core
    import ffc_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int LABEL_BITS = 32
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_write_en,
    input  logic [CFG_INDEX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [1:0]              cmd,
    input  logic [POS_W-1:0]        pos_x,
    input  logic [POS_W-1:0]        pos_y,
    input  logic [LABEL_PORT_W-1:0] write_label,
    input  logic [LABEL_PORT_W-1:0] match_label,
    input  logic [LABEL_PORT_W-1:0] new_label,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [LABEL_PORT_W-1:0] read_label,
    output logic [COUNT_W-1:0]      changed_count
);

    localparam int XW      = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int YW      = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int WW      = $clog2(MAX_WIDTH + 1);
    localparam int HW      = $clog2(MAX_HEIGHT + 1);
    localparam int PIXELS  = MAX_WIDTH * MAX_HEIGHT;
    localparam int PAW     = XW + YW;
    localparam int SAW     = (PIXELS > 1) ? $clog2(PIXELS) : 1;
    localparam int SPW     = $clog2(PIXELS + 1);
    localparam int LB_IN   = (LABEL_BITS < LABEL_PORT_W) ? LABEL_BITS : LABEL_PORT_W;
    localparam int W_RESET = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;
    localparam int H_RESET = (MAX_HEIGHT < 1024) ? MAX_HEIGHT : 1024;

    state_t state_reg, state_next;

    logic [WW-1:0]         width_reg, width_next;
    logic [HW-1:0]         height_reg, height_next;
    logic [XW-1:0]         cur_x_reg, cur_x_next;
    logic [YW-1:0]         cur_y_reg, cur_y_next;
    logic [XW-1:0]         tgt_x_reg, tgt_x_next;
    logic [YW-1:0]         tgt_y_reg, tgt_y_next;
    dir_t                  dir_reg, dir_next;
    logic                  seed_reg, seed_next;
    logic                  rd_inside_reg, rd_inside_next;
    logic [SPW-1:0]        sp_reg, sp_next;
    logic [COUNT_W-1:0]    count_reg, count_next;
    logic [LABEL_BITS-1:0] from_reg, from_next;
    logic [LABEL_BITS-1:0] to_reg, to_next;
    logic                  out_valid_reg, out_valid_next;
    logic [LABEL_PORT_W-1:0] out_label_reg, out_label_next;
    logic [COUNT_W-1:0]    out_count_reg, out_count_next;

    logic                  in_fire;
    logic                  out_load;
    logic                  in_window;
    logic [LABEL_BITS-1:0] in_wl;
    logic [LABEL_BITS-1:0] in_ml;
    logic [LABEL_BITS-1:0] in_nl;
    logic [XW-1:0]         in_x;
    logic [YW-1:0]         in_y;

    logic                  pix_wr_en;
    logic [PAW-1:0]        pix_wr_addr;
    logic [LABEL_BITS-1:0] pix_wr_data;
    logic                  pix_rd_en;
    logic [PAW-1:0]        pix_rd_addr;
    logic [LABEL_BITS-1:0] pix_q;
    logic                  hit;

    logic                  stk_wr_en;
    logic                  stk_rd_en;
    logic [SAW-1:0]        stk_rd_addr;
    logic [PAW-1:0]        stk_q;
    logic [SPW-1:0]        sp_dec;

    logic                  nbr_ok;
    logic [XW-1:0]         nbr_x;
    logic [YW-1:0]         nbr_y;

    logic [DIM_CMP_W-1:0]  cfg_ext;
    logic [DIM_CMP_W-1:0]  w_clamp;
    logic [DIM_CMP_W-1:0]  h_clamp;

    assign in_stall  = (state_reg != S_IDLE) || (out_valid_reg && out_stall);
    assign in_fire   = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign read_label    = out_label_reg;
    assign changed_count = out_count_reg;

    assign in_window = (DIM_CMP_W'(pos_x) < DIM_CMP_W'(width_reg))
                    && (DIM_CMP_W'(pos_y) < DIM_CMP_W'(height_reg));
    assign in_x   = XW'(pos_x);
    assign in_y   = YW'(pos_y);
    assign in_wl  = LABEL_BITS'(write_label[LB_IN-1:0]);
    assign in_ml  = LABEL_BITS'(match_label[LB_IN-1:0]);
    assign in_nl  = LABEL_BITS'(new_label[LB_IN-1:0]);
    assign hit    = pix_q == from_reg;
    assign sp_dec = sp_reg - SPW'(1);

    // Clamp window registers: zero counts as one, above maximum saturates.
    assign cfg_ext = DIM_CMP_W'(cfg_data);
    assign w_clamp = (cfg_ext == '0) ? DIM_CMP_W'(1)
                   : ((cfg_ext > DIM_CMP_W'(MAX_WIDTH)) ? DIM_CMP_W'(MAX_WIDTH) : cfg_ext);
    assign h_clamp = (cfg_ext == '0) ? DIM_CMP_W'(1)
                   : ((cfg_ext > DIM_CMP_W'(MAX_HEIGHT)) ? DIM_CMP_W'(MAX_HEIGHT) : cfg_ext);

    ffc_ram #(
        .DATA_W (LABEL_BITS),
        .DEPTH  (2 ** PAW)
    ) u_pixel_ram (
        .clk     (clk),
        .wr_en   (pix_wr_en),
        .wr_addr (pix_wr_addr),
        .wr_data (pix_wr_data),
        .rd_en   (pix_rd_en),
        .rd_addr (pix_rd_addr),
        .rd_data (pix_q)
    );

    ffc_ram #(
        .DATA_W (PAW),
        .DEPTH  (PIXELS)
    ) u_stack_ram (
        .clk     (clk),
        .wr_en   (stk_wr_en),
        .wr_addr (sp_reg[SAW-1:0]),
        .wr_data ({tgt_y_reg, tgt_x_reg}),
        .rd_en   (stk_rd_en),
        .rd_addr (stk_rd_addr),
        .rd_data (stk_q)
    );

    ffc_nbr_unit #(
        .XW (XW),
        .YW (YW),
        .WW (WW),
        .HW (HW)
    ) u_nbr_unit (
        .cur_x  (cur_x_reg),
        .cur_y  (cur_y_reg),
        .dir    (dir_reg),
        .width  (width_reg),
        .height (height_reg),
        .nbr_ok (nbr_ok),
        .nbr_x  (nbr_x),
        .nbr_y  (nbr_y)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    if (cmd == CMD_READ)
                    begin
                        state_next = S_RDATA;
                    end
                    else if (cmd == CMD_FILL && in_window && in_ml != in_nl)
                    begin
                        state_next = S_TEST;
                    end
                end
            end
            S_RDATA:
            begin
                state_next = S_IDLE;
            end
            S_TEST:
            begin
                if (seed_reg || dir_reg == DIR_UP)
                begin
                    state_next = S_POP;
                end
                else
                begin
                    state_next = S_NBR;
                end
            end
            S_POP:
            begin
                state_next = (sp_reg == '0) ? S_IDLE : S_LOAD;
            end
            S_LOAD:
            begin
                state_next = S_NBR;
            end
            S_NBR:
            begin
                if (nbr_ok)
                begin
                    state_next = S_TEST;
                end
                else if (dir_reg == DIR_UP)
                begin
                    state_next = S_POP;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Datapath and memory controls
    always_comb
    begin
        width_next     = width_reg;
        height_next    = height_reg;
        cur_x_next     = cur_x_reg;
        cur_y_next     = cur_y_reg;
        tgt_x_next     = tgt_x_reg;
        tgt_y_next     = tgt_y_reg;
        dir_next       = dir_reg;
        seed_next      = seed_reg;
        rd_inside_next = rd_inside_reg;
        sp_next        = sp_reg;
        count_next     = count_reg;
        from_next      = from_reg;
        to_next        = to_reg;
        out_load       = 1'b0;
        out_label_next = out_label_reg;
        out_count_next = out_count_reg;
        pix_wr_en      = 1'b0;
        pix_wr_addr    = {tgt_y_reg, tgt_x_reg};
        pix_wr_data    = to_reg;
        pix_rd_en      = 1'b0;
        pix_rd_addr    = {nbr_y, nbr_x};
        stk_wr_en      = 1'b0;
        stk_rd_en      = 1'b0;
        stk_rd_addr    = sp_dec[SAW-1:0];

        if (cfg_write_en)
        begin
            if (cfg_index == CFG_WIDTH)
            begin
                width_next = WW'(w_clamp);
            end
            else if (cfg_index == CFG_HEIGHT)
            begin
                height_next = HW'(h_clamp);
            end
        end

        case (state_reg)
            S_IDLE:
            begin
                pix_wr_addr = {in_y, in_x};
                pix_wr_data = in_wl;
                pix_rd_addr = {in_y, in_x};
                if (in_fire)
                begin
                    rd_inside_next = in_window;
                    tgt_x_next     = in_x;
                    tgt_y_next     = in_y;
                    from_next      = in_ml;
                    to_next        = in_nl;
                    seed_next      = 1'b1;
                    sp_next        = '0;
                    count_next     = '0;
                    out_label_next = '0;
                    out_count_next = '0;
                    if (cmd == CMD_WRITE)
                    begin
                        pix_wr_en = in_window;
                        out_load  = 1'b1;
                    end
                    else if (cmd == CMD_READ)
                    begin
                        pix_rd_en = in_window;
                    end
                    else if (cmd == CMD_FILL && in_window && in_ml != in_nl)
                    begin
                        pix_rd_en = 1'b1;
                    end
                    else
                    begin
                        out_load = 1'b1;
                    end
                end
            end
            S_RDATA:
            begin
                out_load       = 1'b1;
                out_label_next = rd_inside_reg ? LABEL_PORT_W'(pix_q[LB_IN-1:0]) : '0;
                out_count_next = '0;
            end
            S_TEST:
            begin
                if (hit)
                begin
                    pix_wr_en  = 1'b1;
                    stk_wr_en  = 1'b1;
                    sp_next    = sp_reg + SPW'(1);
                    count_next = count_reg + COUNT_W'(1);
                end
                if (seed_reg || dir_reg == DIR_UP)
                begin
                    seed_next = 1'b0;
                end
                else
                begin
                    dir_next = next_dir(dir_reg);
                end
            end
            S_POP:
            begin
                if (sp_reg == '0)
                begin
                    out_load       = 1'b1;
                    out_label_next = '0;
                    out_count_next = count_reg;
                end
                else
                begin
                    stk_rd_en = 1'b1;
                    sp_next   = sp_dec;
                end
            end
            S_LOAD:
            begin
                cur_x_next = stk_q[XW-1:0];
                cur_y_next = stk_q[PAW-1:XW];
                dir_next   = DIR_RIGHT;
            end
            S_NBR:
            begin
                if (nbr_ok)
                begin
                    pix_rd_en  = 1'b1;
                    tgt_x_next = nbr_x;
                    tgt_y_next = nbr_y;
                end
                else if (dir_reg != DIR_UP)
                begin
                    dir_next = next_dir(dir_reg);
                end
            end
            default:
            begin
                out_load = 1'b0;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            width_reg     <= WW'(W_RESET);
            height_reg    <= HW'(H_RESET);
            seed_reg      <= 1'b0;
            sp_reg        <= '0;
            dir_reg       <= DIR_RIGHT;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            width_reg     <= width_next;
            height_reg    <= height_next;
            seed_reg      <= seed_next;
            sp_reg        <= sp_next;
            dir_reg       <= dir_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_x_reg     <= cur_x_next;
        cur_y_reg     <= cur_y_next;
        tgt_x_reg     <= tgt_x_next;
        tgt_y_reg     <= tgt_y_next;
        rd_inside_reg <= rd_inside_next;
        count_reg     <= count_next;
        from_reg      <= from_next;
        to_reg        <= to_next;
        out_label_reg <= out_label_next;
        out_count_reg <= out_count_next;
    end

endmodule
